// ----- src/dtss_pkg.sv -----
// ============================================================================
// dtss_pkg
// Shared types and constants for the delay tracking sample slipper.
// ============================================================================
package dtss_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LAG_START    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIFF_FIRST   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIFF_SECOND  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIFF_THIRD   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_LENGTH = 3'd4;

    // fixed field widths
    localparam int WORD_BITS = 32;
    localparam int LAG_BITS  = 64;
    localparam int FLEN_BITS = 32;

    // input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_PAD    = 1'b1;

    // depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // one classified request handed from front to back
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 two;   // a repeat copy follows the first result
        logic                 pad;   // zero pad word
    } job_t;

endpackage

// ----- src/dtss_front.sv -----
// ============================================================================
// dtss_front
// Accepts requests, advances the cubic delay model and decides how many
// result words each request produces.
// ============================================================================
module dtss_front #(
    parameter int LAG_FRAC_BITS = 32,
    parameter int COUNT_BITS    = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dtss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dtss_pkg::LAG_BITS-1:0]       cfg_data,
    // request side
    input  logic                                accept,
    input  logic                                cmd,
    input  logic [dtss_pkg::WORD_BITS-1:0]      sample_word,
    input  logic                                frame_start,
    // job queue write
    output logic                                job_push,
    output dtss_pkg::job_t                      job
);

    localparam int L = dtss_pkg::LAG_BITS;
    localparam int CMP_BITS = (COUNT_BITS > dtss_pkg::FLEN_BITS) ? COUNT_BITS
                                                                 : dtss_pkg::FLEN_BITS;
    localparam logic signed [L:0]   HALF_SAMPLE = (L+1)'(1) << (LAG_FRAC_BITS - 1);
    localparam logic signed [L:0]   NEG_HALF    = -HALF_SAMPLE;
    localparam logic        [L-1:0] ONE_SAMPLE  = L'(1) << LAG_FRAC_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // configuration registers
    logic [L-1:0]                   lag_start_reg;
    logic [L-1:0]                   diff_first_reg;
    logic [L-1:0]                   diff_second_reg;
    logic [L-1:0]                   diff_third_reg;
    logic [dtss_pkg::FLEN_BITS-1:0] frame_length_reg;

    // model state
    logic [L-1:0]            lag_now_reg,      lag_now_next;
    logic [L-1:0]            diff_one_reg,     diff_one_next;
    logic [L-1:0]            diff_two_reg,     diff_two_next;
    logic [L-1:0]            tracked_step_reg, tracked_step_next;
    logic [COUNT_BITS-1:0]   out_count_reg,    out_count_next;
    logic                    step_set_reg,     step_set_next;

    logic [L-1:0]            lag_base;
    logic [L-1:0]            d1_base;
    logic [L-1:0]            d2_base;
    logic signed [L:0]       lag_err;
    logic                    move_up;
    logic                    move_down;
    logic [COUNT_BITS-1:0]   cnt0;
    logic [COUNT_BITS-1:0]   cnt1;
    logic [COUNT_BITS-1:0]   cnt2;
    logic                    room0;
    logic                    room1;
    logic                    emit_one;
    logic                    emit_two;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_start_reg    <= '0;
            diff_first_reg   <= '0;
            diff_second_reg  <= '0;
            diff_third_reg   <= '0;
            frame_length_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dtss_pkg::REG_LAG_START:    lag_start_reg    <= cfg_data;
                dtss_pkg::REG_DIFF_FIRST:   diff_first_reg   <= cfg_data;
                dtss_pkg::REG_DIFF_SECOND:  diff_second_reg  <= cfg_data;
                dtss_pkg::REG_DIFF_THIRD:   diff_third_reg   <= cfg_data;
                dtss_pkg::REG_FRAME_LENGTH: frame_length_reg <= cfg_data[dtss_pkg::FLEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // accumulator bases, reloaded at frame start
    always_comb
    begin
        lag_base = frame_start ? lag_start_reg  : lag_now_reg;
        d1_base  = frame_start ? diff_first_reg : diff_one_reg;
        d2_base  = frame_start ? diff_second_reg : diff_two_reg;
    end

    // lag against tracked step, exact in one extra bit
    assign lag_err   = $signed({lag_now_reg[L-1], lag_now_reg})
                     - $signed({tracked_step_reg[L-1], tracked_step_reg});
    assign move_up   = !frame_start && step_set_reg && (lag_err >= HALF_SAMPLE);
    assign move_down = !frame_start && step_set_reg && (lag_err <= NEG_HALF);

    // frame fill tracking, saturating count
    always_comb
    begin
        cnt0  = (cmd == dtss_pkg::CMD_SAMPLE && frame_start) ? '0 : out_count_reg;
        cnt1  = (cnt0 == COUNT_MAX) ? cnt0 : cnt0 + 1'b1;
        cnt2  = (cnt1 == COUNT_MAX) ? cnt1 : cnt1 + 1'b1;
        room0 = CMP_BITS'(cnt0) < CMP_BITS'(frame_length_reg);
        room1 = CMP_BITS'(cnt1) < CMP_BITS'(frame_length_reg);
    end

    // classify the request
    always_comb
    begin
        emit_one = 1'b0;
        emit_two = 1'b0;
        if (cmd == dtss_pkg::CMD_PAD)
        begin
            emit_one = room0;
        end
        else if (move_down)
        begin
            emit_one = room0;
            emit_two = room0 && room1;
        end
        else if (!move_up)
        begin
            emit_one = room0;
        end
    end

    // next state
    always_comb
    begin
        lag_now_next      = lag_now_reg;
        diff_one_next     = diff_one_reg;
        diff_two_next     = diff_two_reg;
        tracked_step_next = tracked_step_reg;
        step_set_next     = step_set_reg;
        out_count_next    = emit_two ? cnt2 : (emit_one ? cnt1 : cnt0);
        if (cmd == dtss_pkg::CMD_SAMPLE)
        begin
            lag_now_next  = lag_base + d1_base;
            diff_one_next = d1_base + d2_base;
            diff_two_next = d2_base + diff_third_reg;
            step_set_next = 1'b1;
            if (frame_start || !step_set_reg)
                tracked_step_next = lag_base;
            else if (move_up)
                tracked_step_next = tracked_step_reg + ONE_SAMPLE;
            else if (move_down)
                tracked_step_next = tracked_step_reg - ONE_SAMPLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_now_reg      <= '0;
            diff_one_reg     <= '0;
            diff_two_reg     <= '0;
            tracked_step_reg <= '0;
            out_count_reg    <= '0;
            step_set_reg     <= 1'b0;
        end
        else if (accept)
        begin
            lag_now_reg      <= lag_now_next;
            diff_one_reg     <= diff_one_next;
            diff_two_reg     <= diff_two_next;
            tracked_step_reg <= tracked_step_next;
            out_count_reg    <= out_count_next;
            step_set_reg     <= step_set_next;
        end
    end

    // job to the queue
    assign job_push = accept && emit_one;
    assign job.word = (cmd == dtss_pkg::CMD_PAD) ? '0 : sample_word;
    assign job.two  = emit_two;
    assign job.pad  = (cmd == dtss_pkg::CMD_PAD);

endmodule

// ----- src/dtss_queue.sv -----
// ============================================================================
// dtss_queue
// Short job queue that decouples the front from the result side.
// ============================================================================
module dtss_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  dtss_pkg::job_t wr_job,
    output logic           full,
    input  logic           rd_en,
    output dtss_pkg::job_t rd_job,
    output logic           empty
);

    localparam int DEPTH    = dtss_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    dtss_pkg::job_t        entry_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg,  count_next;
    logic                  do_wr;
    logic                  do_rd;

    assign full   = (count_reg == FULL_CNT);
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

// ----- src/dtss_back.sv -----
// ============================================================================
// dtss_back
// Expands queued jobs into result words and holds the result register.
// ============================================================================
module dtss_back (
    input  logic                           clk,
    input  logic                           rst_n,
    // job queue read
    input  logic                           q_empty,
    input  dtss_pkg::job_t                 q_job,
    output logic                           q_pop,
    // result side
    output logic                           empty,
    input  logic                           pop,
    output logic [dtss_pkg::WORD_BITS-1:0] out_word,
    output logic                           run_last,
    output logic                           is_duplicate,
    output logic                           is_padding
);

    logic                           out_valid_reg;
    logic [dtss_pkg::WORD_BITS-1:0] word_reg;
    logic                           last_reg;
    logic                           dup_reg;
    logic                           pad_reg;
    logic                           pend_reg;
    logic                           load;

    // result register free or being taken
    assign load  = !out_valid_reg || pop;
    assign q_pop = load && !pend_reg && !q_empty;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
                pend_reg      <= 1'b0;
            end
            else
            begin
                out_valid_reg <= !q_empty;
                pend_reg      <= !q_empty && q_job.two;
            end
        end
    end

    // result payload, repeat copy keeps the word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg)
            begin
                last_reg <= 1'b1;
                dup_reg  <= 1'b1;
                pad_reg  <= 1'b0;
            end
            else if (!q_empty)
            begin
                word_reg <= q_job.word;
                last_reg <= !q_job.two;
                dup_reg  <= 1'b0;
                pad_reg  <= q_job.pad;
            end
        end
    end

    assign empty        = !out_valid_reg;
    assign out_word     = word_reg;
    assign run_last     = last_reg;
    assign is_duplicate = dup_reg;
    assign is_padding   = pad_reg;

endmodule

// ----- src/delay_tracking_sample_slipper.sv -----
// ============================================================================
// delay_tracking_sample_slipper
// Integer sample delay compensation driven by a cubic delay model.
// ============================================================================
// A request is accepted in every cycle in which full is low; the front
// advances the delay model and decides on zero, one or two result words in
// that same cycle, so samples stream in at one per cycle. Results leave
// through a single result register at one word per cycle while pop is high,
// each passing through the job queue and then the result register; a sample
// sent twice occupies the result port for both words, and the four-entry
// job queue between front and result side absorbs these bursts and result
// stalls before full rises. Configuration writes are always taken (cfg_ready
// is high) and should be issued only while no request is in flight.
module delay_tracking_sample_slipper #(
    parameter int LAG_FRAC_BITS = 32,
    parameter int COUNT_BITS    = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dtss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dtss_pkg::LAG_BITS-1:0]       cfg_data,
    // request side
    input  logic                                push,
    output logic                                full,
    input  logic                                cmd,
    input  logic [dtss_pkg::WORD_BITS-1:0]      sample_word,
    input  logic                                frame_start,
    // result side
    output logic                                empty,
    input  logic                                pop,
    output logic [dtss_pkg::WORD_BITS-1:0]      out_word,
    output logic                                run_last,
    output logic                                is_duplicate,
    output logic                                is_padding
);

    logic           accept;
    logic           job_push;
    dtss_pkg::job_t job;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    dtss_pkg::job_t q_job;

    assign full   = q_full;
    assign accept = push && !q_full;

    // front: model update and classification
    dtss_front #(
        .LAG_FRAC_BITS (LAG_FRAC_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .cmd         (cmd),
        .sample_word (sample_word),
        .frame_start (frame_start),
        .job_push    (job_push),
        .job         (job)
    );

    // job queue
    dtss_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_job (q_job),
        .empty  (q_empty)
    );

    // back: result expansion
    dtss_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_job        (q_job),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .out_word     (out_word),
        .run_last     (run_last),
        .is_duplicate (is_duplicate),
        .is_padding   (is_padding)
    );

endmodule

// ----- tb/tb_delay_tracking_sample_slipper.sv -----
// ============================================================================
// tb_delay_tracking_sample_slipper
// Self-checking bench for the delay tracking sample slipper.
// ============================================================================
// A clocked driver feeds sample and pad requests from a pending queue while a
// clocked monitor pops result words at random. Every accepted request goes
// through a local copy of the cubic delay tracker, which appends the words
// it should produce to an expected list. Each popped word is checked field
// by field against the head of that list. Registers are only rewritten once
// the block has drained. The run covers a short directed opening, then
// random frames under several register settings and stall patterns,
// including one long result hold-off that fills the block.
module tb_delay_tracking_sample_slipper;

    localparam int CLK_PERIOD   = 12;
    localparam int LAG_FRAC     = 32;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 100;
    localparam int LB           = dtss_pkg::LAG_BITS;
    localparam int WB           = dtss_pkg::WORD_BITS;
    localparam int FB           = dtss_pkg::FLEN_BITS;
    localparam int IB           = dtss_pkg::CFG_INDEX_BITS;

    localparam logic [LB-1:0] SIGN_BIT    = {1'b1, {(LB-1){1'b0}}};
    localparam logic [LB-1:0] LAG_MAX     = {1'b0, {(LB-1){1'b1}}};
    localparam logic [LB-1:0] LAG_MIN     = SIGN_BIT;
    localparam logic [LB-1:0] ONE_SAMPLE  = 64'd1 << LAG_FRAC;
    localparam logic [LB-1:0] HALF_SAMPLE = 64'd1 << (LAG_FRAC - 1);

    // one request as offered on the input side
    typedef struct packed {
        logic          cmd;
        logic [WB-1:0] word;
        logic          fs;
    } request_t;

    // one result word as seen on the output side
    typedef struct packed {
        logic [WB-1:0] word;
        logic          last;
        logic          dup;
        logic          pad;
    } slip_word_t;

    logic          clk;
    logic          rst_n       = 1'b0;
    logic          cfg_valid   = 1'b0;
    logic          cfg_ready;
    logic [IB-1:0] cfg_index   = dtss_pkg::REG_LAG_START;
    logic [LB-1:0] cfg_data    = '0;
    logic          push        = 1'b0;
    logic          full;
    logic          cmd         = dtss_pkg::CMD_SAMPLE;
    logic [WB-1:0] sample_word = '0;
    logic          frame_start = 1'b0;
    logic          empty;
    logic          pop         = 1'b0;
    logic [WB-1:0] out_word;
    logic          run_last;
    logic          is_duplicate;
    logic          is_padding;

    // bench control
    request_t   pending_requests[$];
    slip_word_t expected_words[$];
    request_t   offered;
    int         requests_queued = 0;
    int         requests_taken  = 0;
    int         mismatches      = 0;
    int         tx_idle_pct     = 0;
    int         rx_idle_pct     = 0;
    logic       rx_hold         = 1'b0;
    logic       hold_arm        = 1'b0;

    // register copies
    logic [LB-1:0] cfg_lag0 = '0;
    logic [LB-1:0] cfg_d1   = '0;
    logic [LB-1:0] cfg_d2   = '0;
    logic [LB-1:0] cfg_d3   = '0;
    logic [FB-1:0] cfg_flen = '0;

    // tracker state copy
    logic [LB-1:0] lag_acc    = '0;
    logic [LB-1:0] rate_acc   = '0;
    logic [LB-1:0] curve_acc  = '0;
    logic [LB-1:0] step_track = '0;
    logic [FB-1:0] words_sent = '0;
    logic          step_valid = 1'b0;

    delay_tracking_sample_slipper i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .sample_word  (sample_word),
        .frame_start  (frame_start),
        .empty        (empty),
        .pop          (pop),
        .out_word     (out_word),
        .run_last     (run_last),
        .is_duplicate (is_duplicate),
        .is_padding   (is_padding)
    );

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // overall time limit
    initial
    begin
        #(CLK_PERIOD * 200000);
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // append one expected word and advance the frame count
    function automatic void emit_word(input logic [WB-1:0] word, input logic dup,
                                      input logic pad);
        slip_word_t w;
        w.word = word;
        w.last = 1'b0;
        w.dup  = dup;
        w.pad  = pad;
        expected_words.push_back(w);
        if (words_sent != '1)
            words_sent++;
    endfunction

    // expected words for one accepted request
    function automatic void predict_slip(input request_t rq);
        logic [LB-1:0] lag_b;
        logic [LB-1:0] step_b;
        int            copies;
        int            emitted;
        slip_word_t    w;
        emitted = 0;
        if (rq.cmd == dtss_pkg::CMD_PAD)
        begin
            if (words_sent < cfg_flen)
            begin
                emit_word('0, 1'b0, 1'b1);
                emitted = 1;
            end
        end
        else
        begin
            copies = 1;
            // frame start reloads the model, first sample ever latches the step
            if (rq.fs)
            begin
                lag_acc    = cfg_lag0;
                rate_acc   = cfg_d1;
                curve_acc  = cfg_d2;
                step_track = cfg_lag0;
                words_sent = '0;
                step_valid = 1'b1;
            end
            else if (!step_valid)
            begin
                step_track = lag_acc;
                step_valid = 1'b1;
            end
            // exact signed distance between lag and step
            lag_b  = lag_acc ^ SIGN_BIT;
            step_b = step_track ^ SIGN_BIT;
            if (lag_b >= step_b)
            begin
                if (lag_b - step_b >= HALF_SAMPLE)
                begin
                    step_track = step_track + ONE_SAMPLE;
                    copies     = 0;
                end
            end
            else if (step_b - lag_b >= HALF_SAMPLE)
            begin
                step_track = step_track - ONE_SAMPLE;
                copies     = 2;
            end
            for (int c = 0; c < copies; c++)
            begin
                if (words_sent < cfg_flen)
                begin
                    emit_word(rq.word, c == 1, 1'b0);
                    emitted++;
                end
            end
            // forward differencing of the cubic
            lag_acc   = lag_acc + rate_acc;
            rate_acc  = rate_acc + curve_acc;
            curve_acc = curve_acc + cfg_d3;
        end
        if (emitted > 0)
        begin
            w      = expected_words.pop_back();
            w.last = 1'b1;
            expected_words.push_back(w);
        end
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_slip(offered);
                requests_taken++;
            end
            if (!push || !full)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    offered = pending_requests.pop_front();
                    push        <= 1'b1;
                    cmd         <= offered.cmd;
                    sample_word <= offered.word;
                    frame_start <= offered.fs;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        slip_word_t w;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word %h", out_word));
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (out_word !== w.word)
                        report_mismatch($sformatf("out_word %h, want %h", out_word, w.word));
                    if (run_last !== w.last)
                        report_mismatch($sformatf("run_last %b, want %b", run_last, w.last));
                    if (is_duplicate !== w.dup)
                        report_mismatch($sformatf("is_duplicate %b, want %b", is_duplicate,
                                                  w.dup));
                    if (is_padding !== w.pad)
                        report_mismatch($sformatf("is_padding %b, want %b", is_padding, w.pad));
                end
            end
            pop <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // long result hold-off so the block fills and raises full
    initial
    begin
        wait (hold_arm);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic queue_request(input logic c, input logic [WB-1:0] word,
                                 input logic fs);
        request_t rq;
        rq.cmd  = c;
        rq.word = word;
        rq.fs   = fs;
        pending_requests.push_back(rq);
        requests_queued++;
    endtask

    // wait until every request is taken and every word has come out
    task automatic wait_drained();
        while (requests_taken != requests_queued || expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IB-1:0] idx, input logic [LB-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            dtss_pkg::REG_LAG_START:    cfg_lag0 = value;
            dtss_pkg::REG_DIFF_FIRST:   cfg_d1   = value;
            dtss_pkg::REG_DIFF_SECOND:  cfg_d2   = value;
            dtss_pkg::REG_DIFF_THIRD:   cfg_d3   = value;
            dtss_pkg::REG_FRAME_LENGTH: cfg_flen = value[FB-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [LB-1:0] lag0, input logic [LB-1:0] d1,
                             input logic [LB-1:0] d2, input logic [LB-1:0] d3,
                             input logic [FB-1:0] flen);
        write_reg(dtss_pkg::REG_LAG_START, lag0);
        write_reg(dtss_pkg::REG_DIFF_FIRST, d1);
        write_reg(dtss_pkg::REG_DIFF_SECOND, d2);
        write_reg(dtss_pkg::REG_DIFF_THIRD, d3);
        // upper data bits are junk that the block must drop
        write_reg(dtss_pkg::REG_FRAME_LENGTH, {$urandom, flen});
    endtask

    // random signed value scaled down by an arithmetic shift
    function automatic logic [LB-1:0] scaled_random(input int shift);
        logic signed [LB-1:0] raw;
        raw = {$urandom, $urandom};
        return raw >>> shift;
    endfunction

    // random frames: mostly well formed, some stray starts and pads
    task automatic queue_frames(input int samples);
        int       made;
        int       len;
        int       pads;
        logic     c;
        logic     fs;
        made = 0;
        while (made < samples)
        begin
            len = $urandom_range(1, 40);
            for (int k = 0; k < len; k++)
            begin
                c  = ($urandom_range(99) < 4) ? dtss_pkg::CMD_PAD : dtss_pkg::CMD_SAMPLE;
                fs = (k == 0) ? ($urandom_range(99) >= 5) : ($urandom_range(99) < 3);
                queue_request(c, $urandom, fs);
                if (c == dtss_pkg::CMD_SAMPLE)
                    made++;
            end
            pads = $urandom_range(0, 20);
            for (int k = 0; k < pads; k++)
                queue_request(dtss_pkg::CMD_PAD, $urandom, 1'($urandom_range(1)));
        end
    endtask

    // stimulus sequence
    initial
    begin
        int flavor;
        tx_idle_pct = 6;
        rx_idle_pct = 68;
        wait (rst_n === 1'b1);

        // zero frame length after reset: nothing comes out
        queue_request(dtss_pkg::CMD_SAMPLE, 32'h1234_5678, 1'b0);
        queue_request(dtss_pkg::CMD_PAD, 32'h0, 1'b0);
        wait_drained();

        // rising lag: samples before any frame start, then drops, fill and overflow
        write_all(64'd0, 64'h0000_0000_6000_0000, 64'd0, 64'd0, 32'd12);
        queue_request(dtss_pkg::CMD_SAMPLE, 32'h0000_0000, 1'b0);
        queue_request(dtss_pkg::CMD_SAMPLE, 32'hA5A5_A5A5, 1'b0);
        queue_request(dtss_pkg::CMD_SAMPLE, 32'hFFFF_FFFF, 1'b1);
        for (int k = 0; k < 7; k++)
            queue_request(dtss_pkg::CMD_SAMPLE, $urandom, 1'b0);
        queue_request(dtss_pkg::CMD_PAD, 32'hFFFF_FFFF, 1'b1);
        for (int k = 0; k < 5; k++)
            queue_request(dtss_pkg::CMD_PAD, $urandom, 1'b0);
        wait_drained();

        // falling lag: repeats, second copy cut by a short frame
        write_all(64'd5 << LAG_FRAC, -64'sh6666_6666, 64'h0100_0000,
                  64'hFFFF_FFFF_FFFF_0000, 32'd6);
        queue_request(dtss_pkg::CMD_SAMPLE, $urandom, 1'b1);
        for (int k = 0; k < 5; k++)
            queue_request(dtss_pkg::CMD_SAMPLE, $urandom, 1'b0);
        wait_drained();

        // random phases
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 2)
            begin
                tx_idle_pct = 68;
                rx_idle_pct = 6;
            end
            else if (ph == 4)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            flavor = (ph == 1) ? 1 : (ph == 3) ? 2 : 0;
            case (flavor)
                1: write_all(LAG_MAX, LAG_MAX, LAG_MIN, LAG_MAX, '1);
                2: write_all(LAG_MIN, LAG_MIN, LAG_MAX, LAG_MIN, 32'd1);
                default: write_all(scaled_random(28), scaled_random(31), scaled_random(37),
                                   scaled_random(45), $urandom_range(1, 48));
            endcase
            if (ph == 1)
                hold_arm = 1'b1;
            queue_frames(PHASE_ITEMS);
            wait_drained();
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
